FILE: design/cnlc_pkg.sv
`default_nettype none

package cnlc_pkg;

	localparam int CardWidth = 54;
	localparam int NumDigits = 17;
	localparam int BcdWidth = 4 * NumDigits;
	localparam int CntWidth = 6;
	localparam int MaxDigits = 16;

	localparam logic [1:0] VerdictInvalid = 2'd0;
	localparam logic [1:0] VerdictAmex = 2'd1;
	localparam logic [1:0] VerdictMastercard = 2'd2;
	localparam logic [1:0] VerdictVisa = 2'd3;

	localparam logic [4:0] LenShort = 5'd13;
	localparam logic [4:0] LenMid = 5'd15;
	localparam logic [4:0] LenLong = 5'd16;

	localparam logic [6:0] LeadAmexA = 7'd34;
	localparam logic [6:0] LeadAmexB = 7'd37;
	localparam logic [6:0] LeadMcLow = 7'd50;
	localparam logic [6:0] LeadMcHigh = 7'd56;
	localparam logic [6:0] LeadVisaLow = 7'd40;
	localparam logic [6:0] LeadVisaHigh = 7'd49;

	typedef enum logic [1:0] {
		StIdle,
		StConv,
		StScan,
		StFin
	} state_t;

endpackage

`default_nettype wire

FILE: design/card_number_luhn_classifier.sv
// Channel   Signals                        Handshake
// input     start, busy, card_number       accepted at a clock edge with start high, busy low
// result    done, verdict, checksum_ok     done high for one cycle, receiver cannot stall
//
// Each item passes from acceptance to done through bit-serial binary to BCD
// conversion, a scan of the 17 decimal digits one decimal digit a cycle, and
// a final state that forms the verdict. A new item may start in the cycle done is high.
// The asynchronous reset returns the block to idle with no result pending.
`default_nettype none

module card_number_luhn_classifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [cnlc_pkg::CardWidth-1:0] card_number,
	output logic                                done,
	output logic [1:0]                          verdict,
	output logic                                checksum_ok
);
	import cnlc_pkg::*;

	state_t state_q, state_d;
	logic [CntWidth-1:0] cnt_q;
	logic [CardWidth-1:0] bin_q;
	logic [BcdWidth-1:0] bcd_q;
	logic [BcdWidth-1:0] bcd_adj;
	logic [3:0] sum_q;
	logic [3:0] prev_q;
	logic [4:0] count_q;
	logic [6:0] lead_q;
	logic done_q;
	logic [1:0] verdict_q;
	logic ok_q;
	logic [3:0] dig;
	logic [3:0] term;
	logic [4:0] dbl;
	logic [4:0] sum_raw;
	logic [3:0] sum_next;
	logic [6:0] lead_next;
	logic len_ok;
	logic [1:0] verdict_next;
	logic conv_last;
	logic scan_last;

	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign dig = bcd_q[3:0];
	assign dbl = {dig, 1'b0};
	always_comb begin
		if (!cnt_q[0]) begin
			term = dig;
		end else if (dbl >= 5'd10) begin
			term = 4'(dbl - 5'd9);
		end else begin
			term = dbl[3:0];
		end
	end

	assign sum_raw = {1'b0, sum_q} + {1'b0, term};
	assign sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
	assign lead_next = (cnt_q == '0) ? {3'd0, dig}
	                                 : ({dig, 3'd0} + {2'd0, dig, 1'b0} + {3'd0, prev_q});

	assign conv_last = (cnt_q == CntWidth'(CardWidth - 1));
	assign scan_last = (cnt_q == CntWidth'(NumDigits - 1));

	assign len_ok = (count_q == LenShort || count_q == LenMid || count_q == LenLong)
	             && (count_q <= 5'(MaxDigits));

	always_comb begin
		verdict_next = VerdictInvalid;
		if (sum_q == 4'd0 && len_ok) begin
			if (lead_q == LeadAmexA || lead_q == LeadAmexB) begin
				verdict_next = VerdictAmex;
			end else if (lead_q > LeadMcLow && lead_q < LeadMcHigh) begin
				verdict_next = VerdictMastercard;
			end else if (lead_q >= LeadVisaLow && lead_q <= LeadVisaHigh) begin
				verdict_next = VerdictVisa;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = (state_q != StIdle);
		unique case (state_q)
			StIdle: begin
				if (start) begin
					state_d = StConv;
				end
			end
			StConv: begin
				if (conv_last) begin
					state_d = StScan;
				end
			end
			StScan: begin
				if (scan_last) begin
					state_d = StFin;
				end
			end
			StFin: begin
				state_d = StIdle;
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == StFin);
			if (state_q == StIdle || (state_q == StConv && conv_last)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: begin
				bin_q <= card_number;
				bcd_q <= '0;
				sum_q <= '0;
				prev_q <= '0;
				count_q <= '0;
				lead_q <= '0;
			end
			StConv: begin
				bin_q <= {bin_q[CardWidth-2:0], 1'b0};
				bcd_q <= {bcd_adj[BcdWidth-2:0], bin_q[CardWidth-1]};
			end
			StScan: begin
				bcd_q <= {4'd0, bcd_q[BcdWidth-1:4]};
				sum_q <= sum_next;
				prev_q <= dig;
				if (dig != 4'd0) begin
					count_q <= 5'(cnt_q) + 5'd1;
					lead_q <= lead_next;
				end
			end
			StFin: begin
				verdict_q <= verdict_next;
				ok_q <= (sum_q == 4'd0);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign verdict = verdict_q;
	assign checksum_ok = ok_q;

endmodule

`default_nettype wire

FILE: design/cnlc_checker.sv
`default_nettype none

module cnlc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [1:0] verdict,
	input wire logic       checksum_ok
);
	import cnlc_pkg::*;

	// A result only appears once the block has finished with its item.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not make the block busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_brand_needs_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict != VerdictInvalid) |-> checksum_ok)
		else $error("brand given without a passing checksum");

endmodule

bind card_number_luhn_classifier cnlc_checker u_cnlc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.verdict(verdict),
	.checksum_ok(checksum_ok)
);

`default_nettype wire
